/* sv/imfu_pkg.sv */
// Package for the integer math function unit: widths, operation codes,
// controller states and the command/status structs. No dependencies.
package imfu_pkg;

    localparam int DataWidth = 64;
    localparam int CntWidth  = 7;
    // pow multiplies step through the multiplier in slices of this width
    localparam int SliceWidth = 16;
    // holds twice the largest partial cube root plus one
    localparam int CbrtWidth = 24;
    // from this argument on the factorial wraps to zero at 64 bits
    localparam int FactZeroFrom = 66;

    typedef enum logic [2:0] {
        OP_SQRT = 3'd0,
        OP_CBRT = 3'd1,
        OP_LOG  = 3'd2,
        OP_POW  = 3'd3,
        OP_FACT = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SQRT,
        ST_CBRT_A,
        ST_CBRT_B,
        ST_CBRT_C,
        ST_LOG_CMP,
        ST_LOG_DIV,
        ST_POW_A,
        ST_POW_B,
        ST_FACT,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic setup;
        logic sqrt_step;
        logic cbrt_a;
        logic cbrt_b;
        logic cbrt_c;
        logic log_start;
        logic log_div;
        logic pow_a;
        logic pow_b;
        logic fact_step;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] op;
        logic       err;
        logic       trivial;
        logic       cnt_last;
        logic       log_ge;
        logic       div_busy;
        logic       pow_zero;
        logic       mul_last;
    } stat_t;

endpackage

/* sv/integer_math_function_unit.sv */
// Integer math function unit: one word in, one word out, one at a time.
// Trivial cases (domain errors, unused codes, factorials of arguments up
// to 1 or from 66, logs of negative arguments) go from setup straight to
// the result. Square root, cube root and factorial iterate, power makes
// two passes through the 64x16 multiplier per significant exponent bit,
// and a logarithm divides repeatedly in the bit-serial divider. The
// result sits in an output register until taken; a word is finished
// only once that register is free, and the next input word is accepted
// after that.
// Depends on imfu_pkg, imfu_ctrl, imfu_datapath, imfu_div.
module integer_math_function_unit
    import imfu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [2:0]           req_type,
    input  logic signed [63:0]   operand_a,
    input  logic signed [63:0]   operand_b,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [63:0]   result_value,
    output logic                 status_code
);

    cmd_t                 cmd;
    stat_t                stat;
    logic                 out_load;
    logic [DataWidth-1:0] res;
    logic                 res_err;
    logic                 valid_reg, valid_next;
    logic [DataWidth-1:0] res_reg;
    logic                 err_reg;

    imfu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_take (!valid_reg),
        .out_load (out_load),
        .cmd      (cmd),
        .stat     (stat)
    );

    imfu_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req_type  (req_type),
        .operand_a (operand_a[DataWidth-1:0]),
        .operand_b (operand_b[DataWidth-1:0]),
        .stat      (stat),
        .res       (res),
        .res_err   (res_err)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (valid_reg && !out_stall)
            valid_next = 1'b0;
        else if (out_load && !valid_reg)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load && !valid_reg)
        begin
            res_reg <= res;
            err_reg <= res_err;
        end
    end

    assign out_valid    = valid_reg;
    assign result_value = 64'(signed'(res_reg));
    assign status_code  = err_reg;

endmodule

/* sv/imfu_div.sv */
// Radix-2 restoring divider, one quotient bit a cycle, unsigned.
// Depends on imfu_pkg.
module imfu_div
    import imfu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DataWidth-1:0] dividend,
    input  logic [DataWidth-1:0] divisor,
    output logic                 busy,
    output logic [DataWidth-1:0] quotient
);

    logic [DataWidth-1:0] q_reg, q_next;
    logic [DataWidth-1:0] r_reg, r_next;
    logic [DataWidth-1:0] d_reg, d_next;
    logic [CntWidth-1:0]  n_reg, n_next;
    logic                 busy_reg, busy_next;
    logic [DataWidth:0]   trial;
    logic [DataWidth:0]   shifted;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        n_next    = n_reg;
        busy_next = busy_reg;
        shifted   = {r_reg, q_reg[DataWidth-1]};
        trial     = shifted - {1'b0, d_reg};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            n_next    = CntWidth'(DataWidth - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DataWidth])
            begin
                r_next = trial[DataWidth-1:0];
                q_next = {q_reg[DataWidth-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted[DataWidth-1:0];
                q_next = {q_reg[DataWidth-2:0], 1'b0};
            end
            n_next = n_reg - 1'b1;
            if (n_reg == '0)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        n_reg <= n_next;
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

/* sv/imfu_datapath.sv */
// Datapath: operand registers, digit-recurrence roots, a 64x16 slice
// multiplier and the logarithm divider. Depends on imfu_pkg and imfu_div.
module imfu_datapath
    import imfu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    input  logic [2:0]           req_type,
    input  logic [DataWidth-1:0] operand_a,
    input  logic [DataWidth-1:0] operand_b,
    output stat_t                stat,
    output logic [DataWidth-1:0] res,
    output logic                 res_err
);

    logic [2:0]           op_reg;
    logic [DataWidth-1:0] a_reg, b_reg;
    logic [DataWidth-1:0] x_reg, x_next;   // working value / remainder
    logic [DataWidth-1:0] y_reg, y_next;   // root / result / accumulator
    logic [DataWidth-1:0] z_reg, z_next;   // bit / base / multiplicand
    logic [DataWidth-1:0] t_reg, t_next;   // product scratch
    logic [CntWidth-1:0]  c_reg, c_next;
    logic                 neg_reg, neg_next;
    logic                 err_reg, err_next;
    logic                 triv_reg, triv_next;
    logic [1:0]           m_reg, m_next;     // slice index of a pow multiply
    logic [DataWidth-1:0] acc_reg, acc_next; // partial sum of a pow multiply
    logic [DataWidth-1:0] mul_a, mul_b, mul_p;
    logic [SliceWidth-1:0] mul_s;
    logic [DataWidth+SliceWidth-1:0] mul_full;
    logic [DataWidth-1:0] mul_sum;
    logic [CbrtWidth-1:0] cb_y;
    logic [2*CbrtWidth-1:0] cb_p;
    logic [DataWidth-1:0] sum;
    logic [DataWidth-1:0] shx;
    logic                 div_busy;
    logic [DataWidth-1:0] div_q;

    assign mul_full = mul_a * mul_s;
    assign mul_p    = mul_full[DataWidth-1:0];
    assign mul_sum  = acc_reg + (mul_p << (m_reg * SliceWidth));
    assign cb_y     = {y_reg[CbrtWidth-2:0], 1'b0};
    assign cb_p     = cb_y * (cb_y + 1'b1);
    assign sum      = y_reg + z_reg;
    assign shx      = x_reg >> c_reg;

    imfu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.log_div),
        .dividend (x_reg),
        .divisor  (b_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    always_comb
    begin
        mul_a = y_reg;
        mul_b = z_reg;
        if (cmd.cbrt_b)
        begin
            mul_a = t_reg;
            mul_b = DataWidth'(3);
        end
        else if (cmd.pow_b)
        begin
            mul_a = z_reg;
            mul_b = z_reg;
        end
        else if (cmd.fact_step)
            mul_b = DataWidth'(c_reg);
        mul_s = mul_b[m_reg * SliceWidth +: SliceWidth];
    end

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        t_next    = t_reg;
        c_next    = c_reg;
        neg_next  = neg_reg;
        err_next  = err_reg;
        triv_next = triv_reg;
        m_next    = m_reg;
        acc_next  = acc_reg;
        if (cmd.setup)
        begin
            err_next  = 1'b0;
            triv_next = 1'b0;
            neg_next  = 1'b0;
            y_next    = '0;
            m_next    = '0;
            acc_next  = '0;
            unique case (op_reg)
                OP_SQRT:
                begin
                    err_next  = a_reg[DataWidth-1];
                    triv_next = a_reg[DataWidth-1];
                    x_next    = a_reg;
                    z_next    = DataWidth'(1) << (DataWidth - 2);
                    c_next    = CntWidth'(DataWidth / 2 - 1);
                end
                OP_CBRT:
                begin
                    neg_next = a_reg[DataWidth-1];
                    x_next   = a_reg[DataWidth-1] ? -a_reg : a_reg;
                    c_next   = CntWidth'(((DataWidth - 1) / 3) * 3);
                end
                OP_LOG:
                begin
                    err_next  = b_reg[DataWidth-1] || b_reg < DataWidth'(2);
                    triv_next = err_next || a_reg[DataWidth-1];
                    x_next    = a_reg;
                end
                OP_POW:
                begin
                    err_next  = b_reg[DataWidth-1];
                    triv_next = b_reg[DataWidth-1];
                    y_next    = DataWidth'(1);
                    z_next    = a_reg;
                    x_next    = b_reg;
                end
                OP_FACT:
                begin
                    y_next = DataWidth'(1);
                    if (a_reg[DataWidth-1] || a_reg <= DataWidth'(1))
                        triv_next = 1'b1;
                    else if (a_reg >= DataWidth'(FactZeroFrom))
                    begin
                        triv_next = 1'b1;
                        y_next    = '0;
                    end
                    c_next = CntWidth'(2);
                end
                default:
                begin
                    err_next  = 1'b1;
                    triv_next = 1'b1;
                end
            endcase
        end
        else if (cmd.sqrt_step)
        begin
            if (x_reg >= sum)
            begin
                x_next = x_reg - sum;
                y_next = (y_reg >> 1) + z_reg;
            end
            else
                y_next = y_reg >> 1;
            z_next = z_reg >> 2;
            c_next = c_reg - 1'b1;
        end
        else if (cmd.cbrt_a)
        begin
            y_next = y_reg << 1;
            t_next = DataWidth'(cb_p);
        end
        else if (cmd.cbrt_b)
            t_next = mul_p + 1'b1;
        else if (cmd.cbrt_c)
        begin
            if (shx >= t_reg)
            begin
                x_next = x_reg - (t_reg << c_reg);
                y_next = y_reg + 1'b1;
            end
            c_next = c_reg - CntWidth'(3);
        end
        else if (cmd.log_start)
            x_next = div_q;
        else if (cmd.log_div)
            y_next = y_reg + 1'b1;
        else if (cmd.pow_a)
        begin
            acc_next = mul_sum;
            m_next   = m_reg + 1'b1;
            if (m_reg == '1)
            begin
                acc_next = '0;
                if (x_reg[0])
                    y_next = mul_sum;
            end
        end
        else if (cmd.pow_b)
        begin
            acc_next = mul_sum;
            m_next   = m_reg + 1'b1;
            if (m_reg == '1)
            begin
                acc_next = '0;
                z_next   = mul_sum;
                x_next   = x_reg >> 1;
            end
        end
        else if (cmd.fact_step)
        begin
            y_next = mul_p;
            c_next = c_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= req_type;
            a_reg  <= operand_a;
            b_reg  <= operand_b;
        end
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        t_reg    <= t_next;
        c_reg    <= c_next;
        neg_reg  <= neg_next;
        err_reg  <= err_next;
        triv_reg <= triv_next;
        m_reg    <= m_next;
        acc_reg  <= acc_next;
    end

    always_comb
    begin
        stat.op       = op_reg;
        stat.err      = err_reg;
        // decided in the setup cycle itself
        stat.trivial  = triv_next;
        stat.log_ge   = x_reg >= b_reg;
        stat.div_busy = div_busy;
        stat.pow_zero = x_reg == '0;
        stat.mul_last = m_reg == '1;
        unique case (op_reg)
            OP_FACT: stat.cnt_last = DataWidth'(c_reg) >= a_reg;
            default: stat.cnt_last = c_reg < CntWidth'(3);
        endcase
        if (op_reg == OP_SQRT)
            stat.cnt_last = c_reg == '0;
    end

    assign res     = err_reg ? '0 : (neg_reg ? -y_reg : y_reg);
    assign res_err = err_reg;

endmodule

/* sv/imfu_ctrl.sv */
// Controller state machine sequencing the datapath for each operation.
// Depends on imfu_pkg.
module imfu_ctrl
    import imfu_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  logic  out_take,
    output logic  out_load,
    output cmd_t  cmd,
    input  stat_t stat
);

    state_t state_reg, state_next;
    logic   log_wait_reg, log_wait_next;

    always_comb
    begin
        state_next    = state_reg;
        log_wait_next = log_wait_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_DISPATCH;
            ST_DISPATCH:
            begin
                if (stat.trivial)
                    state_next = ST_DONE;
                else
                begin
                    unique case (stat.op)
                        OP_SQRT: state_next = ST_SQRT;
                        OP_CBRT: state_next = ST_CBRT_A;
                        OP_LOG:  state_next = ST_LOG_CMP;
                        OP_POW:  state_next = ST_POW_A;
                        OP_FACT: state_next = ST_FACT;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_SQRT:     if (stat.cnt_last) state_next = ST_DONE;
            ST_CBRT_A:   state_next = ST_CBRT_B;
            ST_CBRT_B:   state_next = ST_CBRT_C;
            ST_CBRT_C:   state_next = stat.cnt_last ? ST_DONE : ST_CBRT_A;
            ST_LOG_CMP:
            begin
                log_wait_next = 1'b0;
                state_next    = stat.log_ge ? ST_LOG_DIV : ST_DONE;
            end
            ST_LOG_DIV:
            begin
                log_wait_next = 1'b1;
                if (log_wait_reg && !stat.div_busy)
                    state_next = ST_LOG_CMP;
            end
            ST_POW_A:
            begin
                if (stat.pow_zero)
                    state_next = ST_DONE;
                else if (stat.mul_last)
                    state_next = ST_POW_B;
            end
            ST_POW_B:    if (stat.mul_last) state_next = ST_POW_A;
            ST_FACT:     if (stat.cnt_last) state_next = ST_DONE;
            ST_DONE:     if (out_take) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_DISPATCH: cmd.setup = 1'b1;
            ST_SQRT:     cmd.sqrt_step = 1'b1;
            ST_CBRT_A:   cmd.cbrt_a = 1'b1;
            ST_CBRT_B:   cmd.cbrt_b = 1'b1;
            ST_CBRT_C:   cmd.cbrt_c = 1'b1;
            ST_LOG_CMP:  cmd.log_div = stat.log_ge;
            ST_LOG_DIV:  cmd.log_start = log_wait_reg && !stat.div_busy;
            ST_POW_A:    cmd.pow_a = !stat.pow_zero;
            ST_POW_B:    cmd.pow_b = 1'b1;
            ST_FACT:     cmd.fact_step = 1'b1;
            ST_DONE:     out_load = 1'b1;
            default:     cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            log_wait_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            log_wait_reg <= log_wait_next;
        end
    end

endmodule

/* sv/imfu_checker.sv */
// Port-level checker for the integer math function unit, bound to the top.
// Depends on nothing but the top level's ports.
module imfu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] result_value,
    input logic        status_code
);

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status_code |-> result_value == 64'd0)
        else $error("error word with non-zero result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_value))
        else $error("stalled result changed");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word accepted while busy");

    // the word was still in flight in the cycle before its result appeared
    a_out_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a word in flight");

endmodule

bind integer_math_function_unit imfu_checker u_imfu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .status_code  (status_code)
);

/* tb/integer_math_function_unit_checker.sv */
// Checker for the integer math function unit: watches both channels, predicts
// each result from the request word and compares it with the returned word.
// Depends on imfu_pkg and the behaviour of integer_math_function_unit.
module integer_math_function_unit_checker (
    input  logic               clk,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [2:0]         req_type,
    input  logic signed [63:0] operand_a,
    input  logic signed [63:0] operand_b,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [63:0] result_value,
    input  logic               status_code,
    output int                 mismatches,
    output int                 outstanding
);
    import imfu_pkg::*;

    typedef struct packed {
        logic [63:0] value;
        logic        status;
    } answer_t;

    answer_t answers_due[$];

    function automatic logic [63:0] floor_sqrt(logic [63:0] x);
        logic [63:0] root;
        logic [63:0] probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > x)
            probe >>= 2;
        while (probe != 0)
        begin
            if (x >= root + probe)
            begin
                x    = x - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root >>= 1;
            probe >>= 2;
        end
        return root;
    endfunction

    function automatic logic [63:0] floor_cbrt(logic [63:0] x);
        logic [63:0] root;
        logic [63:0] term;
        root = 0;
        for (int sh = 63; sh >= 0; sh -= 3)
        begin
            root = root << 1;
            term = 3 * root * (root + 1) + 1;
            if ((x >> sh) >= term)
            begin
                x    = x - (term << sh);
                root = root + 1;
            end
        end
        return root;
    endfunction

    function automatic answer_t compute_answer(logic [2:0] code, logic [63:0] a,
                                               logic [63:0] b);
        answer_t ans;
        ans = '0;
        case (code)
            OP_SQRT:
                if (a[63]) ans.status = 1'b1;
                else       ans.value  = floor_sqrt(a);
            OP_CBRT:
                if (a[63]) ans.value = 64'd0 - floor_cbrt(64'd0 - a);
                else       ans.value = floor_cbrt(a);
            OP_LOG:
                if (b[63] || b < 2)
                    ans.status = 1'b1;
                else if (!a[63])
                    while (a >= b)
                    begin
                        a         = a / b;
                        ans.value = ans.value + 1;
                    end
            OP_POW:
                if (b[63])
                    ans.status = 1'b1;
                else
                begin
                    ans.value = 1;
                    while (b != 0)
                    begin
                        if (b[0]) ans.value = ans.value * a;
                        a = a * a;
                        b >>= 1;
                    end
                end
            OP_FACT:
                if (a[63] || a <= 1)
                    ans.value = 1;
                else if (a < 66)
                begin
                    ans.value = 1;
                    for (logic [63:0] k = 2; k <= a; k++)
                        ans.value = ans.value * k;
                end
            default:
                ans.status = 1'b1;
        endcase
        return ans;
    endfunction

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    // sample midway through the cycle, when everything has settled
    always @(negedge clk)
    begin
        answer_t want;
        if (in_valid && !in_stall)
            answers_due.push_back(compute_answer(req_type, operand_a, operand_b));
        if (out_valid && !out_stall)
        begin
            if (answers_due.size() == 0)
            begin
                $display("%0t: unexpected result word value=%h status=%b",
                         $time, result_value, status_code);
                mismatches++;
            end
            else
            begin
                want = answers_due.pop_front();
                if (result_value !== want.value)
                begin
                    $display("%0t: result_value expected %h got %h",
                             $time, want.value, result_value);
                    mismatches++;
                end
                if (status_code !== want.status)
                begin
                    $display("%0t: status_code expected %b got %b",
                             $time, want.status, status_code);
                    mismatches++;
                end
            end
        end
        outstanding = answers_due.size();
    end
endmodule

/* tb/integer_math_function_unit_tb.sv */
// Testbench top for integer_math_function_unit: clock, reset, request stimulus
// and result stalling; checking is done in integer_math_function_unit_checker.
module integer_math_function_unit_tb;
    import imfu_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         req_type;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
    logic               out_valid;
    logic               out_stall;
    logic signed [63:0] result_value;
    logic               status_code;
    int                 mismatches;
    int                 outstanding;
    int                 idle_pct;
    int                 stall_pct;
    int                 cycles;

    localparam logic [63:0] MaxPos = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] MinNeg = 64'h8000_0000_0000_0000;
    localparam int          CycleLimit = 3000000;

    integer_math_function_unit dut (.*);

    integer_math_function_unit_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CycleLimit)
            begin
                $display("integer_math_function_unit test failed");
                $finish;
            end
        end
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // hold the word until taken, then maybe leave a gap
    task automatic send_word(logic [2:0] code, logic [63:0] a, logic [63:0] b);
        bit taken;
        in_valid  <= 1'b1;
        req_type  <= code;
        operand_a <= a;
        operand_b <= b;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end while (!taken);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(5))
            0: return {$urandom, $urandom};
            1: return {$urandom, $urandom};
            2: return 64'($urandom_range(0, 70));
            3: return 64'd0 - 64'($urandom_range(0, 70));
            4: return {$urandom, $urandom} >> $urandom_range(0, 63);
            default:
                case ($urandom_range(3))
                    0: return MaxPos;
                    1: return MinNeg;
                    2: return '1;
                    default: return '0;
                endcase
        endcase
    endfunction

    task automatic send_random();
        logic [2:0]  code;
        logic [63:0] a;
        logic [63:0] b;
        code = ($urandom_range(19) == 0) ? 3'($urandom_range(5, 7))
                                         : 3'($urandom_range(0, 4));
        a = pick_operand();
        b = pick_operand();
        if (code == OP_LOG)
        begin
            // long division chains are slow, keep most of them short
            if ($urandom_range(3) == 0)
                b = 64'($urandom_range(2, 16));
            else if ($urandom_range(2) == 0)
                b = {$urandom, $urandom} >> $urandom_range(0, 40);
            if (b < 16 && !b[63] && $urandom_range(3) != 0)
                a = a >> $urandom_range(30, 63);
        end
        send_word(code, a, b);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        req_type  = '0;
        operand_a = '0;
        operand_b = '0;
        idle_pct  = 0;
        stall_pct = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(OP_SQRT, 64'd0, 64'd0);
        send_word(OP_SQRT, 64'd1, '1);
        send_word(OP_SQRT, MaxPos, 64'd0);
        send_word(OP_SQRT, '1, 64'd0);
        send_word(OP_CBRT, MinNeg, 64'd0);
        send_word(OP_CBRT, MaxPos, 64'd0);
        send_word(OP_CBRT, 64'd0 - 27, 64'd0);
        send_word(OP_LOG, 64'd100, 64'd1);
        send_word(OP_LOG, 64'd100, 64'd0 - 5);
        send_word(OP_LOG, 64'd3, 64'd10);
        send_word(OP_LOG, 64'd0 - 50, 64'd3);
        send_word(OP_LOG, MaxPos, 64'd2);
        send_word(OP_POW, 64'd7, '1);
        send_word(OP_POW, 64'd0, 64'd0);
        send_word(OP_POW, 64'd2, 64'd63);
        send_word(OP_POW, '1, MaxPos);
        send_word(OP_FACT, 64'd0, 64'd0);
        send_word(OP_FACT, 64'd0 - 5, 64'd0);
        send_word(OP_FACT, 64'd20, 64'd0);
        send_word(OP_FACT, 64'd65, 64'd0);
        send_word(OP_FACT, 64'd66, 64'd0);
        send_word(OP_FACT, MaxPos, 64'd0);
        send_word(3'd5, 64'd4, 64'd4);
        send_word(3'd7, MinNeg, MaxPos);

        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct  = (phase == 1 || phase == 3) ? 76 : 0;
            stall_pct = (phase == 2) ? 76 : (phase == 3) ? 17 : 0;
            if (phase == 3)
                idle_pct = 17;
            repeat (256) send_random();
        end
        in_valid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (mismatches == 0)
            $display("integer_math_function_unit test passed");
        else
            $display("integer_math_function_unit test failed");
        $finish;
    end
endmodule

/* integer_math_function_unit.f */
sv/imfu_pkg.sv
sv/imfu_div.sv
sv/imfu_datapath.sv
sv/imfu_ctrl.sv
sv/integer_math_function_unit.sv
sv/imfu_checker.sv
tb/integer_math_function_unit_checker.sv
tb/integer_math_function_unit_tb.sv
